[sv/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_NOTE    = 3'd4;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic load_seg;  // pick segment, latch ramp operands
    logic mul;       // multiply and seed the divider
    logic div_step;  // one quotient bit
    logic load_out;  // move level into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic emit;      // accepted beat produces a result
    logic out_free;  // output register can take a new level
  } stat_t;

endpackage

`default_nettype wire

[sv/adsr_ifs.sv]
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface adsr_in_if;
  logic valid;
  logic ready;
  logic start_note;

  modport source (output valid, output start_note, input ready);
  modport sink   (input valid, input start_note, output ready);
endinterface

interface adsr_out_if #(
  parameter int LEVEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  last_sample;

  modport source (output valid, output level, output last_sample, input ready);
  modport sink   (input valid, input level, input last_sample, output ready);
endinterface

`default_nettype wire

[sv/adsr_ctrl.sv]
// Sequencer: accept, segment select, multiply, shift-subtract divide, hand off.
`default_nettype none

module adsr_ctrl #(
  parameter int LEVEL_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire adsr_pkg::stat_t stat,
  output adsr_pkg::cmd_t      cmd
);

  localparam int CntBits = $clog2(LEVEL_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && stat.emit) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_seg = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CntBits'(LEVEL_BITS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CntBits'(1);
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/adsr_dp.sv]
// Datapath: config registers, note state, ramp multiply, divider, output register.
`default_nettype none

module adsr_dp #(
  parameter int COUNT_BITS = 24,
  parameter int LEVEL_BITS = 16,
  parameter int CFG_BITS   = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]               cfg_wdata,
  input  wire logic                              start_note,
  input  wire adsr_pkg::cmd_t                    cmd,
  output adsr_pkg::stat_t                        stat,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [LEVEL_BITS-1:0]                  out_level,
  output logic                                   out_last
);

  localparam int ProdBits = COUNT_BITS + LEVEL_BITS;
  localparam logic [LEVEL_BITS-1:0] FullScale  = {1'b1, {(LEVEL_BITS-1){1'b0}}};
  localparam logic [LEVEL_BITS-1:0] SusDefault = {2'b01, {(LEVEL_BITS-2){1'b0}}};

  // Config registers
  logic [COUNT_BITS-1:0] attack_r, decay_r, release_r, note_r;
  logic [LEVEL_BITS-1:0] sustain_r;

  // Note state
  logic [COUNT_BITS-1:0] idx_r, len_r, ae_r, de_r, rs_r;
  logic [LEVEL_BITS-1:0] held_r;
  logic                  active_r, last_r;

  // Ramp operands and divider
  logic [LEVEL_BITS-1:0] v0_r, dv_r;
  logic                  rise_r;
  logic [COUNT_BITS-1:0] span_r, step_r, rem_r;
  logic [LEVEL_BITS-1:0] quo_r;

  // Output register
  logic                  out_valid_r;
  logic [LEVEL_BITS-1:0] out_level_r;
  logic                  out_last_r;

  // Beat evaluation
  logic [COUNT_BITS-1:0] idx_inc, idx_new, len_new;
  logic                  emit, last_new;
  logic [COUNT_BITS:0]   ad_sum;
  logic [COUNT_BITS-1:0] ae_nxt, de_nxt, rs_nxt;
  logic [LEVEL_BITS-1:0] held_nxt;

  always_comb begin
    idx_inc = idx_r + COUNT_BITS'(1);
    if (start_note) begin
      len_new = note_r;
      idx_new = '0;
      emit    = (note_r != '0);
    end else begin
      len_new = len_r;
      idx_new = idx_inc;
      emit    = active_r && (idx_inc < len_r);
    end
    last_new = ((idx_new + COUNT_BITS'(1)) == len_new);

    ad_sum   = {1'b0, attack_r} + {1'b0, decay_r};
    ae_nxt   = (attack_r > note_r) ? note_r : attack_r;
    de_nxt   = (ad_sum > {1'b0, note_r}) ? note_r : ad_sum[COUNT_BITS-1:0];
    rs_nxt   = (release_r >= note_r) ? '0 : note_r - release_r;
    held_nxt = (sustain_r > FullScale) ? FullScale : sustain_r;
  end

  // Segment select: release overrides everything; sustain is a zero-depth ramp
  logic [LEVEL_BITS-1:0] seg_v0, seg_dv;
  logic                  seg_rise;
  logic [COUNT_BITS-1:0] seg_span, seg_step;

  always_comb begin
    if (idx_r >= rs_r) begin
      seg_v0   = held_r;
      seg_dv   = held_r;
      seg_rise = 1'b0;
      seg_span = len_r - rs_r;
      seg_step = idx_r - rs_r;
    end else if (idx_r >= de_r) begin
      seg_v0   = held_r;
      seg_dv   = '0;
      seg_rise = 1'b0;
      seg_span = COUNT_BITS'(1);
      seg_step = '0;
    end else if (idx_r >= ae_r) begin
      seg_v0   = FullScale;
      seg_dv   = FullScale - held_r;
      seg_rise = 1'b0;
      seg_span = de_r - ae_r;
      seg_step = idx_r - ae_r;
    end else begin
      seg_v0   = '0;
      seg_dv   = FullScale;
      seg_rise = 1'b1;
      seg_span = ae_r;
      seg_step = idx_r;
    end
  end

  // Multiply; quotient < dv, so the high part of the product is already < span
  logic [ProdBits-1:0] prod;
  assign prod = {{COUNT_BITS{1'b0}}, dv_r} * {{LEVEL_BITS{1'b0}}, step_r};

  // Restoring divide, one quotient bit per cycle, dividend low bits share quo_r
  logic [COUNT_BITS:0] trial, diff;
  logic                ge;
  always_comb begin
    trial = {rem_r, quo_r[LEVEL_BITS-1]};
    diff  = trial - {1'b0, span_r};
    ge    = (trial >= {1'b0, span_r});
  end

  logic [LEVEL_BITS-1:0] level_nxt;
  assign level_nxt = rise_r ? (v0_r + quo_r) : (v0_r - quo_r);

  assign stat.emit     = emit;
  assign stat.out_free = !out_valid_r || out_ready;

  // Control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r    <= '0;
      decay_r     <= '0;
      sustain_r   <= SusDefault;
      release_r   <= '0;
      note_r      <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      ae_r        <= '0;
      de_r        <= '0;
      rs_r        <= '0;
      held_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          adsr_pkg::REG_ATTACK:  attack_r  <= cfg_wdata[COUNT_BITS-1:0];
          adsr_pkg::REG_DECAY:   decay_r   <= cfg_wdata[COUNT_BITS-1:0];
          adsr_pkg::REG_SUSTAIN: sustain_r <= cfg_wdata[LEVEL_BITS-1:0];
          adsr_pkg::REG_RELEASE: release_r <= cfg_wdata[COUNT_BITS-1:0];
          adsr_pkg::REG_NOTE:    note_r    <= cfg_wdata[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (start_note) begin
          len_r  <= note_r;
          ae_r   <= ae_nxt;
          de_r   <= de_nxt;
          rs_r   <= rs_nxt;
          held_r <= held_nxt;
        end
        if (start_note || active_r) begin
          idx_r    <= idx_new;
          active_r <= emit && !last_new;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_r <= last_new;
    end
    if (cmd.load_seg) begin
      v0_r   <= seg_v0;
      dv_r   <= seg_dv;
      rise_r <= seg_rise;
      span_r <= seg_span;
      step_r <= seg_step;
    end
    if (cmd.mul) begin
      rem_r <= prod[ProdBits-1:LEVEL_BITS];
      quo_r <= prod[LEVEL_BITS-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_r <= {quo_r[LEVEL_BITS-2:0], ge};
    end
    if (cmd.load_out) begin
      out_level_r <= level_nxt;
      out_last_r  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[sv/adsr_envelope_generator_unit.sv]
// Top level of the linear ADSR envelope generator.
//
//  channel  | dir | beat payload              | handshake
//  ---------+-----+---------------------------+------------------------------
//  in_bus   | in  | start_note                | valid & ready
//  out_bus  | out | level, last_sample        | valid & ready
//  cfg_*    | in  | cfg_index, cfg_wdata      | cfg_we, no back-pressure
//
// An input beat that yields a level passes through accept, segment select,
// multiply, LEVEL_BITS steps of the shift-subtract divider (one quotient bit
// per step), then hand-off to the output register once that register is free.
// A beat with no result leaves the sequencer idle.
// Reset is synchronous and active low; it clears the sequencer, note state,
// config registers (sustain to half scale) and the output valid.
// A stalled output holds its level; the next input beat is taken meanwhile,
// and its result waits in the sequencer until the output register frees up.
`default_nettype none

module adsr_envelope_generator_unit #(
  parameter  int COUNT_BITS = 24,
  parameter  int LEVEL_BITS = 16,
  localparam int CfgBits    = (COUNT_BITS > LEVEL_BITS) ? COUNT_BITS : LEVEL_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CfgBits-1:0]                cfg_wdata,
  adsr_in_if.sink                                in_bus,
  adsr_out_if.source                             out_bus
);

  adsr_pkg::cmd_t  cmd;
  adsr_pkg::stat_t stat;
  logic            in_ready;

  // Sequencer
  adsr_ctrl #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_bus.ready = in_ready;

  // Note state, ramp arithmetic and output register
  adsr_dp #(
    .COUNT_BITS (COUNT_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .CFG_BITS   (CfgBits)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start_note (in_bus.start_note),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_level  (out_bus.level),
    .out_last   (out_bus.last_sample)
  );

endmodule

`default_nettype wire

[sv/adsr_chk.sv]
// Port-level checker for the envelope generator, bound to the top level.
`default_nettype none

module adsr_chk #(
  parameter int LEVEL_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [LEVEL_BITS-1:0] level,
  input wire logic                  last_sample
);

  localparam logic [LEVEL_BITS-1:0] FullScale = {1'b1, {(LEVEL_BITS-1){1'b0}}};

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(last_sample))
    else $error("stalled result beat changed");

  // New result only appears after the sequencer left idle
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while sequencer was idle");

  // Level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> level <= FullScale)
    else $error("level above full scale");

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind adsr_envelope_generator_unit adsr_chk #(
  .LEVEL_BITS (LEVEL_BITS)
) u_adsr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .level       (out_bus.level),
  .last_sample (out_bus.last_sample)
);

`default_nettype wire
